// ----- rtl/occ_pkg.sv -----
// ----------------------------------------------------------------------------
// occ_pkg
// Shared types, constants and the arctangent table of the coarse CFO block.
// ----------------------------------------------------------------------------
package occ_pkg;

    localparam int WINDOW_LEN_DEF = 48;
    localparam int CORDIC_STEPS   = 24;
    localparam int DIV_STEPS      = 16;
    localparam int PADDR_W        = 4;

    localparam logic [15:0] THRESH_RST = 16'd58982;
    localparam logic [10:0] LAG_RST    = 11'd16;
    localparam logic [15:0] HOLD_RST   = 16'd320;

    localparam logic [PADDR_W-1:0] ADDR_THRESH = 4'd0;
    localparam logic [PADDR_W-1:0] ADDR_LAG    = 4'd4;
    localparam logic [PADDR_W-1:0] ADDR_HOLD   = 4'd8;

    // round(2^30 / CORDIC gain)
    localparam logic signed [30:0] GAIN_INV = 31'sd652032874;

    typedef struct packed {
        logic signed [15:0] mr;
        logic signed [15:0] mi;
        logic signed [15:0] lr;
        logic signed [15:0] li;
    } t_pair;

    typedef struct packed {
        logic [15:0] thresh;
        logic [10:0] lag;
        logic [15:0] hold;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PROD_CUR,
        S_ACC_CUR,
        S_MUL_GO,
        S_MUL_WAIT,
        S_CMP,
        S_VEC_INIT,
        S_VEC,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_ROT_INIT,
        S_ROT,
        S_GAIN,
        S_PROD_OLD,
        S_ACC_OLD,
        S_OUT
    } t_state;

    // atan(2^-i) in pi/2^24 units
    function automatic logic [24:0] atan_lut(input logic [4:0] i);
        logic [24:0] v;
        case (i)
            5'd0:    v = 25'd4194304;
            5'd1:    v = 25'd2476042;
            5'd2:    v = 25'd1308273;
            5'd3:    v = 25'd664101;
            5'd4:    v = 25'd333339;
            5'd5:    v = 25'd166832;
            5'd6:    v = 25'd83436;
            5'd7:    v = 25'd41721;
            5'd8:    v = 25'd20861;
            5'd9:    v = 25'd10430;
            5'd10:   v = 25'd5215;
            5'd11:   v = 25'd2608;
            5'd12:   v = 25'd1304;
            5'd13:   v = 25'd652;
            5'd14:   v = 25'd326;
            5'd15:   v = 25'd163;
            5'd16:   v = 25'd81;
            5'd17:   v = 25'd41;
            5'd18:   v = 25'd20;
            5'd19:   v = 25'd10;
            5'd20:   v = 25'd5;
            5'd21:   v = 25'd3;
            5'd22:   v = 25'd1;
            5'd23:   v = 25'd1;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/ofdm_coarse_cfo_estimate_correct_top.sv -----
// ----------------------------------------------------------------------------
// ofdm_coarse_cfo_estimate_correct_top
// Coarse CFO estimation by delayed autocorrelation, with derotation.
//
//   port group  direction  handshake            payload
//   sample in   in         i_valid / o_stall    i_main_re/im, i_lagged_re/im
//   result out  out        o_valid / i_stall    o_fixed_re/im, o_cfo_tag,
//                                               o_cfo_estimate
//   registers   in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One sample pair is processed at a time by the back end sequencer: it
// skips the detection test while the holdoff runs, the test makes five
// passes through the 64x64 multiplier, and a new estimate is taken with a
// 24-step vectoring CORDIC and 16-step divider.
// A two-entry input queue and an output register let both sides stall
// independently. Synchronous active-low reset clears sums, phase and window.
// ----------------------------------------------------------------------------
module ofdm_coarse_cfo_estimate_correct_top import occ_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_main_re,
    input  logic signed [15:0]  i_main_im,
    input  logic signed [15:0]  i_lagged_re,
    input  logic signed [15:0]  i_lagged_im,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_fixed_re,
    output logic signed [15:0]  o_fixed_im,
    output logic                o_cfo_tag,
    output logic signed [15:0]  o_cfo_estimate,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    t_cfg  r_cfg;
    t_pair in_pair;
    t_pair q_pair;
    logic  q_avail;
    logic  q_pop;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh <= THRESH_RST;
            r_cfg.lag    <= LAG_RST;
            r_cfg.hold   <= HOLD_RST;
        end else if (wr_en) begin
            case (paddr)
                ADDR_THRESH: r_cfg.thresh <= pwdata[15:0];
                ADDR_LAG:    r_cfg.lag    <= pwdata[10:0];
                ADDR_HOLD:   r_cfg.hold   <= pwdata[15:0];
                default:     r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_THRESH: prdata = {16'd0, r_cfg.thresh};
            ADDR_LAG:    prdata = {21'd0, r_cfg.lag};
            ADDR_HOLD:   prdata = {16'd0, r_cfg.hold};
            default:     prdata = 32'd0;
        endcase
    end

    assign in_pair.mr = i_main_re;
    assign in_pair.mi = i_main_im;
    assign in_pair.lr = i_lagged_re;
    assign in_pair.li = i_lagged_im;

    occ_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pair  (in_pair),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_pair  (q_pair)
    );

    occ_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_avail        (q_avail),
        .i_pair         (q_pair),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_fixed_re     (o_fixed_re),
        .o_fixed_im     (o_fixed_im),
        .o_cfo_tag      (o_cfo_tag),
        .o_cfo_estimate (o_cfo_estimate)
    );

endmodule

// ----- rtl/occ_ram.sv -----
// ----------------------------------------------------------------------------
// occ_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module occ_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/occ_front.sv -----
// ----------------------------------------------------------------------------
// occ_front
// Input side: takes sample pairs from the stream into a two-entry queue.
// ----------------------------------------------------------------------------
module occ_front import occ_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_pair i_pair,
    input  logic  i_pop,
    output logic  o_avail,
    output t_pair o_pair
);

    t_pair      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_pair  = r_q[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_pair;
        end
    end

endmodule

// ----- rtl/occ_mul.sv -----
// ----------------------------------------------------------------------------
// occ_mul
// 64 x 64 unsigned multiplier, one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module occ_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic         r_busy;
    logic         r_done;
    logic [1:0]   r_cnt;
    logic [127:0] r_acc;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp;
    logic [1:0]   sh_sel;
    logic [127:0] pp_sh;

    assign a_part = r_cnt[1] ? i_a[63:32] : i_a[31:0];
    assign b_part = r_cnt[0] ? i_b[63:32] : i_b[31:0];
    assign pp     = a_part * b_part;
    assign sh_sel = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
    assign pp_sh  = {64'd0, pp} << {sh_sel, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- rtl/occ_back.sv -----
// ----------------------------------------------------------------------------
// occ_back
// Sample processing: sliding sums, detection test, angle, step division,
// derotation of the window-delayed sample and the output register.
// ----------------------------------------------------------------------------
module occ_back import occ_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_avail,
    input  t_pair              i_pair,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_fixed_re,
    output logic signed [15:0] o_fixed_im,
    output logic               o_cfo_tag,
    output logic signed [15:0] o_cfo_estimate
);

    localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    localparam logic [2:0] JOB_PMT = 3'd0;
    localparam logic [2:0] JOB_PLT = 3'd1;
    localparam logic [2:0] JOB_RHS = 3'd2;
    localparam logic [2:0] JOB_SQR = 3'd3;
    localparam logic [2:0] JOB_SQI = 3'd4;

    localparam logic signed [64:0] RND_HALF = 65'sd1 <<< 43;

    t_state r_state;
    t_state n_state;

    // architectural state
    logic [AW-1:0]         r_wpos;
    logic [WINDOW_LEN-1:0] r_valid;
    logic signed [38:0]    r_csr;
    logic signed [38:0]    r_csi;
    logic [37:0]           r_pms;
    logic [37:0]           r_pls;
    logic [15:0]           r_hold;
    logic [15:0]           r_step;
    logic [15:0]           r_accum;
    logic                  r_tag;
    logic                  r_o_valid;
    logic [2:0]            r_job;
    logic [4:0]            r_it;

    // working registers
    t_pair              r_cur;
    t_pair              r_old;
    logic signed [31:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri;
    logic signed [31:0] r_p_mr2, r_p_mi2, r_p_lr2, r_p_li2;
    logic [63:0]        r_pmt;
    logic [63:0]        r_plt;
    logic [127:0]       r_rhs;
    logic [127:0]       r_lhs;
    logic signed [41:0] r_vx, r_vy;
    logic signed [26:0] r_vz;
    logic [15:0]        r_num;
    logic [10:0]        r_rem;
    logic [15:0]        r_q;
    logic               r_neg;
    logic signed [33:0] r_rx, r_ry;
    logic signed [26:0] r_rt;
    logic signed [64:0] r_gx, r_gy;
    logic signed [15:0] r_fre, r_fim;
    logic [15:0]        r_est;
    logic               r_otag;

    // combinational
    logic               ram_we;
    logic               ram_re;
    logic               mul_start;
    logic               mul_done;
    logic [127:0]       mul_prod;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    t_pair              ram_rd;
    logic [AW-1:0]      oldest;
    t_pair              pm;
    logic signed [38:0] d_cre, d_cim;
    logic [37:0]        d_pm, d_pl;
    logic [38:0]        mag_re, mag_im;
    logic [127:0]       lhs_sh;
    logic               out_free;
    logic signed [41:0] vx0, vy0, vsx, vsy;
    logic signed [26:0] v_atan;
    logic signed [26:0] z_rnd;
    logic [15:0]        angle;
    logic [15:0]        ang_mag;
    logic [10:0]        div_d;
    logic [11:0]        div_t;
    logic               div_ge;
    logic signed [33:0] rx0, ry0, rsx, rsy;
    logic signed [26:0] ph_ext;
    logic signed [26:0] rt0;
    logic signed [64:0] gx_sh, gy_sh;
    logic signed [15:0] sat_re, sat_im;

    assign oldest   = (r_wpos == AW'(WINDOW_LEN - 1)) ? '0 : r_wpos + 1'b1;
    assign out_free = !r_o_valid || !i_stall;

    occ_ram #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (WINDOW_LEN)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata (i_pair),
        .i_re    (ram_re),
        .i_raddr (oldest),
        .o_rdata (ram_rd)
    );

    occ_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // sum terms of one pair
    assign pm    = (r_state == S_PROD_OLD) ? r_old : r_cur;
    assign d_cre = 39'(r_p_rr) + 39'(r_p_ii);
    assign d_cim = 39'(r_p_ir) - 39'(r_p_ri);
    assign d_pm  = 38'(r_p_mr2) + 38'(r_p_mi2);
    assign d_pl  = 38'(r_p_lr2) + 38'(r_p_li2);

    // detection operands
    assign mag_re = r_csr[38] ? 39'(-r_csr) : 39'(r_csr);
    assign mag_im = r_csi[38] ? 39'(-r_csi) : 39'(r_csi);
    assign lhs_sh = {r_lhs[95:0], 32'd0};

    always_comb begin
        case (r_job)
            JOB_PMT: begin
                mul_a = {26'd0, r_pms};
                mul_b = {48'd0, i_cfg.thresh};
            end
            JOB_PLT: begin
                mul_a = {26'd0, r_pls};
                mul_b = {48'd0, i_cfg.thresh};
            end
            JOB_RHS: begin
                mul_a = r_pmt;
                mul_b = r_plt;
            end
            JOB_SQR: begin
                mul_a = {25'd0, mag_re};
                mul_b = {25'd0, mag_re};
            end
            JOB_SQI: begin
                mul_a = {25'd0, mag_im};
                mul_b = {25'd0, mag_im};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // vectoring
    assign vx0    = 42'(r_csr);
    assign vy0    = 42'(r_csi);
    assign vsx    = r_vx >>> r_it;
    assign vsy    = r_vy >>> r_it;
    assign v_atan = signed'({2'b00, atan_lut(r_it)});
    assign z_rnd  = r_vz + 27'sd256;
    assign angle  = z_rnd[24:9];
    assign ang_mag = angle[15] ? 16'(-angle) : angle;

    // step division, lag of zero taken as one
    assign div_d  = (i_cfg.lag == 11'd0) ? 11'd1 : i_cfg.lag;
    assign div_t  = {r_rem, r_num[15]};
    assign div_ge = (div_t >= {1'b0, div_d});

    // rotation
    assign rx0    = {{4{r_old.mr[15]}}, r_old.mr, 14'd0};
    assign ry0    = {{4{r_old.mi[15]}}, r_old.mi, 14'd0};
    assign ph_ext = {{11{r_accum[15]}}, r_accum};
    assign rt0    = -(ph_ext <<< 9);
    assign rsx    = r_rx >>> r_it;
    assign rsy    = r_ry >>> r_it;

    // round and saturate
    assign gx_sh = (r_gx + RND_HALF) >>> 44;
    assign gy_sh = (r_gy + RND_HALF) >>> 44;
    assign sat_re = (gx_sh > 65'sd32767) ? 16'sh7fff :
                    (gx_sh < -65'sd32768) ? 16'sh8000 : gx_sh[15:0];
    assign sat_im = (gy_sh > 65'sd32767) ? 16'sh7fff :
                    (gy_sh < -65'sd32768) ? 16'sh8000 : gy_sh[15:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    n_state = S_PROD_CUR;
                end
            end
            S_PROD_CUR: n_state = S_ACC_CUR;
            S_ACC_CUR: begin
                n_state = (r_hold != 16'd0) ? S_ROT_INIT : S_MUL_GO;
            end
            S_MUL_GO: n_state = S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (mul_done) begin
                    n_state = (r_job == JOB_SQI) ? S_CMP : S_MUL_GO;
                end
            end
            S_CMP: n_state = (lhs_sh > r_rhs) ? S_VEC_INIT : S_ROT_INIT;
            S_VEC_INIT: n_state = S_VEC;
            S_VEC: begin
                if (r_it == 5'(CORDIC_STEPS - 1)) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (r_it == 5'(DIV_STEPS - 1)) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: n_state = S_ROT_INIT;
            S_ROT_INIT: n_state = S_ROT;
            S_ROT: begin
                if (r_it == 5'(CORDIC_STEPS - 1)) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: n_state = S_PROD_OLD;
            S_PROD_OLD: n_state = S_ACC_OLD;
            S_ACC_OLD: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        mul_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop  = i_avail;
                ram_we = i_avail;
                ram_re = i_avail;
            end
            S_MUL_GO: mul_start = 1'b1;
            default: begin
                o_pop     = 1'b0;
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wpos    <= '0;
            r_valid   <= '0;
            r_csr     <= '0;
            r_csi     <= '0;
            r_pms     <= '0;
            r_pls     <= '0;
            r_hold    <= '0;
            r_step    <= '0;
            r_accum   <= '0;
            r_tag     <= 1'b0;
            r_o_valid <= 1'b0;
            r_job     <= '0;
            r_it      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_valid[r_wpos] <= 1'b1;
                        r_tag           <= 1'b0;
                    end
                end
                S_ACC_CUR: begin
                    r_csr <= r_csr + d_cre;
                    r_csi <= r_csi + d_cim;
                    r_pms <= r_pms + d_pm;
                    r_pls <= r_pls + d_pl;
                    r_job <= JOB_PMT;
                    if (r_hold != 16'd0) begin
                        r_hold <= r_hold - 16'd1;
                    end
                end
                S_MUL_WAIT: begin
                    if (mul_done && r_job != JOB_SQI) begin
                        r_job <= r_job + 3'd1;
                    end
                end
                S_VEC_INIT, S_DIV_INIT, S_ROT_INIT: r_it <= '0;
                S_VEC, S_DIV, S_ROT: r_it <= r_it + 5'd1;
                S_DIV_END: begin
                    r_step <= r_neg ? 16'(-r_q) : r_q;
                    r_hold <= i_cfg.hold;
                    r_tag  <= 1'b1;
                end
                S_ACC_OLD: begin
                    r_csr  <= r_csr - d_cre;
                    r_csi  <= r_csi - d_cim;
                    r_pms  <= r_pms - d_pm;
                    r_pls  <= r_pls - d_pl;
                    r_wpos <= oldest;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_accum <= r_accum + r_step;
                    end
                end
                default: r_it <= r_it;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cur <= i_pair;
            end
            S_PROD_CUR, S_PROD_OLD: begin
                if (r_state == S_PROD_CUR) begin
                    r_old <= r_valid[oldest] ? ram_rd : '0;
                end
                r_p_rr  <= pm.mr * pm.lr;
                r_p_ii  <= pm.mi * pm.li;
                r_p_ir  <= pm.mi * pm.lr;
                r_p_ri  <= pm.mr * pm.li;
                r_p_mr2 <= pm.mr * pm.mr;
                r_p_mi2 <= pm.mi * pm.mi;
                r_p_lr2 <= pm.lr * pm.lr;
                r_p_li2 <= pm.li * pm.li;
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    case (r_job)
                        JOB_PMT: r_pmt <= mul_prod[63:0];
                        JOB_PLT: r_plt <= mul_prod[63:0];
                        JOB_RHS: r_rhs <= mul_prod;
                        JOB_SQR: r_lhs <= mul_prod;
                        JOB_SQI: r_lhs <= r_lhs + mul_prod;
                        default: r_lhs <= r_lhs;
                    endcase
                end
            end
            S_VEC_INIT: begin
                if (vx0 < 0) begin
                    r_vx <= -vx0;
                    r_vy <= -vy0;
                    r_vz <= (vy0 >= 0) ? 27'sd16777216 : -27'sd16777216;
                end else begin
                    r_vx <= vx0;
                    r_vy <= vy0;
                    r_vz <= '0;
                end
            end
            S_VEC: begin
                if (r_vy > 0) begin
                    r_vx <= r_vx + vsy;
                    r_vy <= r_vy - vsx;
                    r_vz <= r_vz + v_atan;
                end else begin
                    r_vx <= r_vx - vsy;
                    r_vy <= r_vy + vsx;
                    r_vz <= r_vz - v_atan;
                end
            end
            S_DIV_INIT: begin
                r_neg <= angle[15];
                r_num <= ang_mag + {6'd0, div_d[10:1]};
                r_rem <= '0;
                r_q   <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? 11'(div_t - {1'b0, div_d}) : div_t[10:0];
                r_q   <= {r_q[14:0], div_ge};
                r_num <= {r_num[14:0], 1'b0};
            end
            S_ROT_INIT: begin
                // fold into the right half-plane first
                if (rt0 > 27'sd8388608) begin
                    r_rx <= -rx0;
                    r_ry <= -ry0;
                    r_rt <= rt0 - 27'sd16777216;
                end else if (rt0 < -27'sd8388608) begin
                    r_rx <= -rx0;
                    r_ry <= -ry0;
                    r_rt <= rt0 + 27'sd16777216;
                end else begin
                    r_rx <= rx0;
                    r_ry <= ry0;
                    r_rt <= rt0;
                end
            end
            S_ROT: begin
                if (r_rt >= 0) begin
                    r_rx <= r_rx - rsy;
                    r_ry <= r_ry + rsx;
                    r_rt <= r_rt - v_atan;
                end else begin
                    r_rx <= r_rx + rsy;
                    r_ry <= r_ry - rsx;
                    r_rt <= r_rt + v_atan;
                end
            end
            S_GAIN: begin
                r_gx <= r_rx * GAIN_INV;
                r_gy <= r_ry * GAIN_INV;
            end
            S_OUT: begin
                if (out_free) begin
                    r_fre  <= sat_re;
                    r_fim  <= sat_im;
                    r_otag <= r_tag;
                    r_est  <= r_step;
                end
            end
            default: r_fre <= r_fre;
        endcase
    end

    assign o_valid        = r_o_valid;
    assign o_fixed_re     = r_fre;
    assign o_fixed_im     = r_fim;
    assign o_cfo_tag      = r_otag;
    assign o_cfo_estimate = signed'(r_est);

endmodule
